// ===== hdl/snpy_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package snpy_pkg;
	localparam int unsigned WINDOW_DEFAULT = 65536;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_VARINT   = 3'd1;
	localparam logic [2:0] ST_TRUNC    = 3'd2;
	localparam logic [2:0] ST_OVERRUN  = 3'd3;
	localparam logic [2:0] ST_OFFSET   = 3'd4;
	localparam logic [2:0] ST_MISMATCH = 3'd5;
	localparam logic [2:0] ST_TOOLARGE = 3'd6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_byte_valid;
		logic       out_last;
		logic [2:0] status;
	} out_item_t;
endpackage
`default_nettype wire

// ===== hdl/snpy_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface snpy_in_if;
	logic               valid;
	logic               ready;
	snpy_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/snpy_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface snpy_out_if;
	logic                valid;
	logic                ready;
	snpy_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/snpy_hist.sv =====
`timescale 1ns / 1ps
`default_nettype none
module snpy_hist #(
	parameter int unsigned AW = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/snappy_block_decompressor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload
// src     | in  | in_byte, in_last
// dst     | out | out_byte, out_byte_valid, out_last, status
// A literal byte loads the output register; input waits until that item leaves before it
// takes the next byte. A copy's last operand byte leads to a check, then two steps per
// emitted byte: read history, then write back and send once the output register is free.
// Input is not ready during a copy or while a result sits in the output register. Reset
// clears all control state; history is not cleared and is never read before being
// written in a block.
module snappy_block_decompressor #(
	parameter int unsigned WINDOW = snpy_pkg::WINDOW_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	snpy_in_if.sink   src,
	snpy_out_if.source dst
);
	localparam int unsigned AW = $clog2(WINDOW);

	typedef enum logic [2:0] {
		P_VARINT, P_TAG, P_EXTLEN, P_LIT, P_OPER
	} phase_t;
	typedef enum logic [1:0] {S_IN, S_CHECK, S_READ, S_EMIT} seq_t;

	phase_t      phase_q;
	seq_t        seq_q;
	logic [31:0] declared_q, produced_q, acc_q;
	logic [6:0]  shift_q;
	logic [7:0]  tag_q;
	logic [2:0]  left_q;
	logic [32:0] lit_q;
	logic        err_q;
	logic        last_q;
	logic [6:0]  copy_q;
	logic        ov_q;
	snpy_pkg::out_item_t od_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	wire logic        acc_in = src.valid && src.ready;
	wire logic [7:0]  b = src.data.in_byte;
	wire logic        lst = src.data.in_last;
	wire logic [31:0] owed = declared_q - produced_q;

	assign src.ready = (seq_q == S_IN) && !ov_q;
	assign dst.valid = ov_q;
	assign dst.data  = od_q;

	assign raddr = AW'(produced_q - acc_q);
	assign waddr = AW'(produced_q);
	assign we    = (seq_q == S_EMIT && !ov_q) || (acc_in && !err_q && phase_q == P_LIT);
	assign wdata = (seq_q == S_EMIT) ? rdata : b;

	snpy_hist #(.AW(AW)) u_hist (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	function automatic logic [2:0] op_total(logic [7:0] t, logic ext);
		logic [2:0] r;
		if (ext) r = 3'(t[7:2] - 6'd59);
		else case (t[1:0])
			2'd1:    r = 3'd1;
			2'd2:    r = 3'd2;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

	logic [31:0] chunk_sh, acc_n, cpy_len;
	logic [2:0]  idx;
	always_comb begin
		chunk_sh = 32'(b[6:0]) << shift_q[4:0];
		idx      = 3'(op_total(tag_q, phase_q == P_EXTLEN) - left_q) & 3'd3;
		acc_n    = acc_q | (32'(b) << {idx[1:0], 3'b000});
		cpy_len  = (tag_q[1:0] == 2'd1) ? 32'(tag_q[4:2]) + 32'd4 : 32'(tag_q[7:2]) + 32'd1;
	end

	task automatic clear_block();
		phase_q    <= P_VARINT;
		declared_q <= '0;
		shift_q    <= '0;
		produced_q <= '0;
		tag_q      <= '0;
		acc_q      <= '0;
		left_q     <= '0;
		lit_q      <= '0;
		err_q      <= 1'b0;
	endtask

	// Load the output register with one item.
	task automatic finish(logic [7:0] d, logic v, logic [2:0] code, logic l);
		ov_q <= 1'b1;
		od_q <= '{out_byte: d, out_byte_valid: v, out_last: l, status: code};
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_block();
			seq_q  <= S_IN;
			last_q <= 1'b0;
			copy_q <= '0;
			ov_q   <= 1'b0;
			od_q   <= '0;
		end else begin
			if (dst.valid && dst.ready) ov_q <= 1'b0;
			case (seq_q)
			S_IN: if (acc_in) begin
				last_q <= lst;
				if (err_q) begin
					if (lst) clear_block();
				end else case (phase_q)
				P_VARINT: begin
					logic bad;
					bad = (shift_q >= 7'd32) ? (b[6:0] != 7'd0) :
					      (shift_q != 7'd0 && (33'(b[6:0]) >> (7'd32 - shift_q)) != 33'd0);
					if (bad) begin
						finish(8'd0, 1'b0, snpy_pkg::ST_TOOLARGE, 1'b1);
						if (lst) clear_block(); else err_q <= 1'b1;
					end else if (b[7] && shift_q + 7'd7 > 7'd63) begin
						finish(8'd0, 1'b0, snpy_pkg::ST_VARINT, 1'b1);
						if (lst) clear_block(); else err_q <= 1'b1;
					end else if (lst) begin
						finish(8'd0, 1'b0, b[7] ? snpy_pkg::ST_TRUNC :
						       ((declared_q | chunk_sh) != 32'd0 ? snpy_pkg::ST_MISMATCH :
						        snpy_pkg::ST_OK), 1'b1);
						clear_block();
					end else begin
						if (shift_q < 7'd32) declared_q <= declared_q | chunk_sh;
						if (b[7]) shift_q <= shift_q + 7'd7;
						else phase_q <= P_TAG;
					end
				end
				P_TAG: begin
					logic [2:0] code;
					code = (b[1:0] == 2'd0 && b[7:2] < 6'd60 && 32'(b[7:2]) + 32'd1 > owed) ?
					       snpy_pkg::ST_OVERRUN : snpy_pkg::ST_OK;
					if (code != snpy_pkg::ST_OK) begin
						finish(8'd0, 1'b0, code, 1'b1);
						if (lst) clear_block(); else err_q <= 1'b1;
					end else if (lst) begin
						// every tag still owes bytes
						finish(8'd0, 1'b0, snpy_pkg::ST_TRUNC, 1'b1);
						clear_block();
					end else begin
						tag_q <= b;
						acc_q <= (b[1:0] == 2'd1) ? {21'd0, b[7:5], 8'd0} : '0;
						if (b[1:0] == 2'd0) begin
							if (b[7:2] < 6'd60) begin
								lit_q <= 33'(b[7:2]) + 33'd1;
								phase_q <= P_LIT;
							end else begin
								left_q <= 3'(b[7:2] - 6'd59);
								phase_q <= P_EXTLEN;
							end
						end else begin
							left_q <= op_total(b, 1'b0);
							phase_q <= P_OPER;
						end
					end
				end
				P_EXTLEN, P_OPER: begin
					if (left_q == 3'd1 && phase_q == P_OPER) begin
						acc_q  <= acc_n;
						left_q <= left_q - 3'd1;
						seq_q  <= S_CHECK;
					end else if (left_q == 3'd1 && 33'(acc_n) + 33'd1 > 33'(owed)) begin
						finish(8'd0, 1'b0, snpy_pkg::ST_OVERRUN, 1'b1);
						if (lst) clear_block(); else err_q <= 1'b1;
					end else if (lst) begin
						finish(8'd0, 1'b0, snpy_pkg::ST_TRUNC, 1'b1);
						clear_block();
					end else begin
						acc_q  <= acc_n;
						left_q <= left_q - 3'd1;
						if (left_q == 3'd1) begin
							lit_q <= 33'(acc_n) + 33'd1;
							phase_q <= P_LIT;
						end
					end
				end
				P_LIT: begin
					if (lst) begin
						finish(b, 1'b1, (lit_q != 33'd1) ? snpy_pkg::ST_TRUNC :
						       (produced_q + 32'd1 != declared_q) ? snpy_pkg::ST_MISMATCH :
						       snpy_pkg::ST_OK, 1'b1);
						clear_block();
					end else begin
						produced_q <= produced_q + 32'd1;
						lit_q <= lit_q - 33'd1;
						if (lit_q == 33'd1) phase_q <= P_TAG;
						finish(b, 1'b1, snpy_pkg::ST_OK, 1'b0);
					end
				end
				default: phase_q <= P_TAG;
				endcase
			end
			S_CHECK: begin
				logic [2:0] code;
				code = snpy_pkg::ST_OK;
				if (acc_q == 32'd0 || acc_q > produced_q) code = snpy_pkg::ST_OFFSET;
				else if (acc_q > 32'(WINDOW)) code = snpy_pkg::ST_TOOLARGE;
				else if (cpy_len > owed) code = snpy_pkg::ST_OVERRUN;
				if (code != snpy_pkg::ST_OK) begin
					finish(8'd0, 1'b0, code, 1'b1);
					if (last_q) clear_block(); else err_q <= 1'b1;
					seq_q <= S_IN;
				end else begin
					copy_q <= 7'(cpy_len);
					phase_q <= P_TAG;
					seq_q <= S_READ;
				end
			end
			S_READ: seq_q <= S_EMIT;
			S_EMIT: if (!ov_q) begin
				if (copy_q == 7'd1 && last_q) begin
					finish(rdata, 1'b1, (produced_q + 32'd1 != declared_q) ?
					       snpy_pkg::ST_MISMATCH : snpy_pkg::ST_OK, 1'b1);
					clear_block();
					seq_q <= S_IN;
				end else begin
					produced_q <= produced_q + 32'd1;
					copy_q <= copy_q - 7'd1;
					finish(rdata, 1'b1, snpy_pkg::ST_OK, 1'b0);
					seq_q <= (copy_q == 7'd1) ? S_IN : S_READ;
				end
			end
			default: seq_q <= S_IN;
			endcase
		end
	end

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != S_IN) |-> !src.ready) else $error("input taken during copy");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(dst.valid && !dst.data.out_byte_valid) |-> dst.data.out_last)
		else $error("status item without last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dst.valid && !dst.ready) |=> dst.valid) else $error("result dropped");
endmodule
`default_nettype wire
